/* src/rws_pkg.sv */
// Shared types, token codes, automaton state codes and reserved word tables of the word scanner.
package rws_pkg;

    localparam int CH_W     = 8;
    localparam int TOKEN_W  = 4;
    localparam int STATE_W  = 4;
    localparam int COUNT_W  = 4;
    localparam int NUM_RW   = 19;
    localparam int RW_CHARS = 12;

    typedef logic [CH_W-1:0]     ch_t;
    typedef logic [TOKEN_W-1:0]  token_t;
    typedef logic [STATE_W-1:0]  dfa_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [NUM_RW-1:0]   hits_t;
    typedef logic [RW_CHARS*8-1:0] rw_text_t;

    localparam token_t TOK_WORD1  = 4'd0;
    localparam token_t TOK_WORD2  = 4'd1;
    localparam token_t TOK_PERIOD = 4'd2;
    localparam token_t TOK_ERROR  = 4'd14;
    localparam token_t TOK_EOFM   = 4'd15;

    localparam dfa_t DFA_Q0   = 4'd0;
    localparam dfa_t DFA_Q1   = 4'd1;
    localparam dfa_t DFA_Q2   = 4'd2;
    localparam dfa_t DFA_Q3   = 4'd3;
    localparam dfa_t DFA_Q4   = 4'd4;
    localparam dfa_t DFA_Q5   = 4'd5;
    localparam dfa_t DFA_Q6   = 4'd6;
    localparam dfa_t DFA_Q7   = 4'd7;
    localparam dfa_t DFA_DEAD = 4'd8;

    localparam count_t COUNT_MAX = 4'd15;
    localparam int     EOFM_INDEX = 18;

    // Each word is right-justified in its vector; the first letter sits highest.
    localparam rw_text_t RW_TEXT [NUM_RW] = '{
        rw_text_t'("masu"), rw_text_t'("masen"), rw_text_t'("mashita"),
        rw_text_t'("masendeshita"), rw_text_t'("desu"), rw_text_t'("deshita"),
        rw_text_t'("o"), rw_text_t'("wa"), rw_text_t'("ni"), rw_text_t'("watashi"),
        rw_text_t'("anata"), rw_text_t'("kare"), rw_text_t'("kanojo"),
        rw_text_t'("sore"), rw_text_t'("mata"), rw_text_t'("soshite"),
        rw_text_t'("shikashi"), rw_text_t'("dakara"), rw_text_t'("eofm")
    };

    localparam count_t RW_LEN [NUM_RW] = '{
        4'd4, 4'd5, 4'd7, 4'd12, 4'd4, 4'd7, 4'd1, 4'd2, 4'd2, 4'd7,
        4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd7, 4'd8, 4'd6, 4'd4
    };

    localparam token_t RW_TYPE [NUM_RW] = '{
        4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12,
        4'd12, 4'd12, 4'd12, 4'd12, 4'd13, 4'd13, 4'd13, 4'd13, 4'd15
    };

    function automatic logic is_space(input ch_t c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_vowel(input ch_t c);
        return (c == "a") || (c == "e") || (c == "i") || (c == "o") || (c == "u") ||
               (c == "I") || (c == "E");
    endfunction

endpackage

/* src/rws_char_if.sv */
// Input byte channel with valid and ready.
interface rws_char_if;
    import rws_pkg::*;

    logic valid;
    logic ready;
    ch_t  ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

/* src/rws_token_if.sv */
// Output token channel with valid and ready.
interface rws_token_if;
    import rws_pkg::*;

    logic   valid;
    logic   ready;
    token_t token_type;

    modport source (output valid, output token_type, input ready);
    modport sink (input valid, input token_type, output ready);
endinterface

/* src/rws_dfa_step.sv */
// Next-state logic of the romaji syllable automaton for one byte.
module rws_dfa_step (
    input  rws_pkg::dfa_t state,
    input  rws_pkg::ch_t  ch,
    output rws_pkg::dfa_t next_state
);
    import rws_pkg::*;

    logic vowel;
    dfa_t start_next;

    assign vowel = is_vowel(ch);

    always_comb
    begin
        if (vowel)
        begin
            start_next = DFA_Q1;
        end
        else
        begin
            case (ch)
                "d", "j", "w", "y", "z":                start_next = DFA_Q6;
                "b", "g", "h", "k", "m", "n", "p", "r": start_next = DFA_Q5;
                "t":                                    start_next = DFA_Q4;
                "c":                                    start_next = DFA_Q3;
                "s":                                    start_next = DFA_Q7;
                default:                                start_next = DFA_DEAD;
            endcase
        end
    end

    always_comb
    begin
        unique case (state)
            DFA_Q0, DFA_Q2: next_state = start_next;
            DFA_Q1:         next_state = (ch == "n") ? DFA_Q2 : start_next;
            DFA_Q3:         next_state = (ch == "h") ? DFA_Q6 : DFA_DEAD;
            DFA_Q4:         next_state = (ch == "s") ? DFA_Q6 : (vowel ? DFA_Q1 : DFA_DEAD);
            DFA_Q5:         next_state = (ch == "y") ? DFA_Q6 : (vowel ? DFA_Q1 : DFA_DEAD);
            DFA_Q6:         next_state = vowel ? DFA_Q1 : DFA_DEAD;
            DFA_Q7:         next_state = (ch == "h") ? DFA_Q6 : (vowel ? DFA_Q1 : DFA_DEAD);
            default:        next_state = DFA_DEAD;
        endcase
    end
endmodule

/* src/romaji_word_token_scanner_unit.sv */
// Top level of the romaji word scanner: per-word state, reserved word matching, token register.
// A token is in the output register in the cycle after its closing whitespace byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the output register is empty or
// drained in the same cycle.
// Reset clears the word state to the start state with all match bits set and empties
// the output register; no clearing pass is needed.
module romaji_word_token_scanner_unit (
    input logic         clk,
    input logic         rst_n,
    rws_char_if.sink    char_s,
    rws_token_if.source token_s
);
    import rws_pkg::*;

    dfa_t   dfa_state_reg, dfa_state_next;
    count_t char_count_reg, char_count_next;
    hits_t  hits_reg, hits_next;
    logic   upper_vowel_reg, upper_vowel_next;
    logic   first_dot_reg, first_dot_next;
    logic   out_valid_reg, out_valid_next;
    token_t token_reg, token_next;

    logic   in_fire;
    logic   out_fire;
    logic   ch_space;
    dfa_t   dfa_step;
    token_t token_sel;

    assign char_s.ready     = !out_valid_reg || token_s.ready;
    assign in_fire          = char_s.valid && char_s.ready;
    assign out_fire         = out_valid_reg && token_s.ready;
    assign ch_space         = is_space(char_s.ch);
    assign token_s.valid      = out_valid_reg;
    assign token_s.token_type = token_reg;

    rws_dfa_step u_dfa (
        .state      (dfa_state_reg),
        .ch         (char_s.ch),
        .next_state (dfa_step)
    );

    always_comb
    begin
        logic full_hit;
        token_sel = upper_vowel_reg ? TOK_WORD2 : TOK_WORD1;
        for (int i = 0; i < NUM_RW; i++)
        begin
            full_hit = hits_reg[i] && (char_count_reg == RW_LEN[i]);
            if (full_hit)
            begin
                token_sel = RW_TYPE[i];
            end
        end
        if (hits_reg[EOFM_INDEX] && (char_count_reg == RW_LEN[EOFM_INDEX]))
        begin
            token_sel = TOK_EOFM;
        end
        else if (dfa_state_reg > DFA_Q2)
        begin
            token_sel = ((char_count_reg == 4'd1) && first_dot_reg) ? TOK_PERIOD : TOK_ERROR;
        end
    end

    always_comb
    begin
        logic [3:0] pos;
        ch_t        rw_ch;
        pos              = 4'd0;
        rw_ch            = '0;
        dfa_state_next   = dfa_state_reg;
        char_count_next  = char_count_reg;
        hits_next        = hits_reg;
        upper_vowel_next = upper_vowel_reg;
        first_dot_next   = first_dot_reg;
        out_valid_next   = out_fire ? 1'b0 : out_valid_reg;
        token_next       = token_reg;
        if (in_fire)
        begin
            if (!ch_space)
            begin
                for (int i = 0; i < NUM_RW; i++)
                begin
                    pos   = RW_LEN[i] - 4'd1 - char_count_reg;
                    rw_ch = RW_TEXT[i][{pos, 3'b000} +: 8];
                    if (!((char_count_reg < RW_LEN[i]) && (rw_ch == char_s.ch)))
                    begin
                        hits_next[i] = 1'b0;
                    end
                end
                if (char_count_reg == 4'd0)
                begin
                    first_dot_next = (char_s.ch == ".");
                end
                upper_vowel_next = (char_s.ch == "I") || (char_s.ch == "E");
                dfa_state_next   = dfa_step;
                if (char_count_reg != COUNT_MAX)
                begin
                    char_count_next = char_count_reg + 4'd1;
                end
            end
            else if (char_count_reg != 4'd0)
            begin
                out_valid_next   = 1'b1;
                token_next       = token_sel;
                dfa_state_next   = DFA_Q0;
                char_count_next  = 4'd0;
                hits_next        = '1;
                upper_vowel_next = 1'b0;
                first_dot_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dfa_state_reg   <= DFA_Q0;
            char_count_reg  <= 4'd0;
            hits_reg        <= '1;
            upper_vowel_reg <= 1'b0;
            first_dot_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            dfa_state_reg   <= dfa_state_next;
            char_count_reg  <= char_count_next;
            hits_reg        <= hits_next;
            upper_vowel_reg <= upper_vowel_next;
            first_dot_reg   <= first_dot_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        token_reg <= token_next;
    end

    // The automaton never leaves its nine defined states.
    assert property (@(posedge clk) disable iff (!rst_n) dfa_state_reg <= DFA_DEAD)
        else $error("automaton state out of range");

    // No reserved word is longer than twelve bytes, so longer words match nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_count_reg > 4'd12) |-> (hits_reg == '0))
        else $error("match bits set on an overlong word");

    // A closing whitespace byte clears the word state and loads a token.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ch_space && (char_count_reg != 4'd0)) |=>
        (out_valid_reg && (char_count_reg == 4'd0) && (hits_reg == '1)))
        else $error("word not closed after whitespace");

    // A new token appears only after an accepted whitespace byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire && ch_space))
        else $error("token without closing whitespace");
endmodule

/* verif/rws_token_checker.sv */
// Token checker for the romaji word scanner: predicts each token from the accepted bytes.
`timescale 1ns / 100ps

module rws_token_checker (
    input  logic        clk,
    input  logic        rst_n,
    rws_char_if         text_m,
    rws_token_if        token_m,
    output int unsigned fail_count,
    output int unsigned outstanding
);
    import rws_pkg::*;

    typedef enum logic [3:0] {
        TK_WORD1       = 4'd0,
        TK_WORD2       = 4'd1,
        TK_PERIOD      = 4'd2,
        TK_VERB        = 4'd3,
        TK_VERBNEG     = 4'd4,
        TK_VERBPAST    = 4'd5,
        TK_VERBPASTNEG = 4'd6,
        TK_IS          = 4'd7,
        TK_WAS         = 4'd8,
        TK_OBJECT      = 4'd9,
        TK_SUBJECT     = 4'd10,
        TK_DESTINATION = 4'd11,
        TK_PRONOUN     = 4'd12,
        TK_CONNECTOR   = 4'd13,
        TK_ERROR       = 4'd14,
        TK_EOFM        = 4'd15
    } tk_e;

    localparam int   N_RESERVED  = 19;
    localparam int   EOFM_SLOT   = 18;
    localparam ch_t  ASCII_SPACE = 8'd32;
    localparam ch_t  ASCII_TAB   = 8'd9;
    localparam ch_t  ASCII_CR    = 8'd13;

    dfa_t                  scan_state;
    count_t                word_len;
    logic [N_RESERVED-1:0] live_words;
    logic                  ends_upper_vowel;
    logic                  starts_dot;
    tk_e                   expected_tokens[$];

    function automatic string reserved_text(input int idx);
        case (idx)
            0:       return "masu";
            1:       return "masen";
            2:       return "mashita";
            3:       return "masendeshita";
            4:       return "desu";
            5:       return "deshita";
            6:       return "o";
            7:       return "wa";
            8:       return "ni";
            9:       return "watashi";
            10:      return "anata";
            11:      return "kare";
            12:      return "kanojo";
            13:      return "sore";
            14:      return "mata";
            15:      return "soshite";
            16:      return "shikashi";
            17:      return "dakara";
            default: return "eofm";
        endcase
    endfunction

    function automatic tk_e reserved_kind(input int idx);
        case (idx)
            0:                  return TK_VERB;
            1:                  return TK_VERBNEG;
            2:                  return TK_VERBPAST;
            3:                  return TK_VERBPASTNEG;
            4:                  return TK_IS;
            5:                  return TK_WAS;
            6:                  return TK_OBJECT;
            7:                  return TK_SUBJECT;
            8:                  return TK_DESTINATION;
            9, 10, 11, 12, 13:  return TK_PRONOUN;
            14, 15, 16, 17:     return TK_CONNECTOR;
            default:            return TK_EOFM;
        endcase
    endfunction

    function automatic logic blank_byte(input ch_t c);
        return (c == ASCII_SPACE) || ((c >= ASCII_TAB) && (c <= ASCII_CR));
    endfunction

    function automatic logic vowel_byte(input ch_t c);
        return (c == "a") || (c == "e") || (c == "i") || (c == "o") || (c == "u") ||
               (c == "I") || (c == "E");
    endfunction

    function automatic dfa_t lead_step(input ch_t c);
        if (vowel_byte(c))
        begin
            return DFA_Q1;
        end
        case (c)
            "d", "j", "w", "y", "z":                return DFA_Q6;
            "b", "g", "h", "k", "m", "n", "p", "r": return DFA_Q5;
            "t":                                    return DFA_Q4;
            "c":                                    return DFA_Q3;
            "s":                                    return DFA_Q7;
            default:                                return DFA_DEAD;
        endcase
    endfunction

    function automatic dfa_t syllable_step(input dfa_t st, input ch_t c);
        case (st)
            DFA_Q0, DFA_Q2: return lead_step(c);
            DFA_Q1:         return (c == "n") ? DFA_Q2 : lead_step(c);
            DFA_Q3:         return (c == "h") ? DFA_Q6 : DFA_DEAD;
            DFA_Q4:         return (c == "s") ? DFA_Q6 : (vowel_byte(c) ? DFA_Q1 : DFA_DEAD);
            DFA_Q5:         return (c == "y") ? DFA_Q6 : (vowel_byte(c) ? DFA_Q1 : DFA_DEAD);
            DFA_Q6:         return vowel_byte(c) ? DFA_Q1 : DFA_DEAD;
            DFA_Q7:         return (c == "h") ? DFA_Q6 : (vowel_byte(c) ? DFA_Q1 : DFA_DEAD);
            default:        return DFA_DEAD;
        endcase
    endfunction

    function automatic logic whole_match(input int idx);
        return live_words[idx] && (int'(word_len) == reserved_text(idx).len());
    endfunction

    task automatic clear_word();
        scan_state       = DFA_Q0;
        word_len         = '0;
        live_words       = '1;
        ends_upper_vowel = 1'b0;
        starts_dot       = 1'b0;
    endtask

    task automatic scan_byte(input ch_t c);
        string txt;
        tk_e   tok;
        if (!blank_byte(c))
        begin
            for (int i = 0; i < N_RESERVED; i++)
            begin
                txt = reserved_text(i);
                if (!((int'(word_len) < txt.len()) && (ch_t'(txt[word_len]) == c)))
                begin
                    live_words[i] = 1'b0;
                end
            end
            if (word_len == '0)
            begin
                starts_dot = (c == ".");
            end
            ends_upper_vowel = (c == "I") || (c == "E");
            scan_state       = syllable_step(scan_state, c);
            if (word_len != COUNT_MAX)
            begin
                word_len = word_len + 1'b1;
            end
        end
        else if (word_len != '0)
        begin
            if (whole_match(EOFM_SLOT))
            begin
                tok = TK_EOFM;
            end
            else if (scan_state <= DFA_Q2)
            begin
                tok = ends_upper_vowel ? TK_WORD2 : TK_WORD1;
                for (int i = 0; i < N_RESERVED; i++)
                begin
                    if (whole_match(i))
                    begin
                        tok = reserved_kind(i);
                    end
                end
            end
            else if ((word_len == 4'd1) && starts_dot)
            begin
                tok = TK_PERIOD;
            end
            else
            begin
                tok = TK_ERROR;
            end
            expected_tokens.push_back(tok);
            clear_word();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tk_e want;
        if (!rst_n)
        begin
            clear_word();
            expected_tokens.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (token_m.valid && token_m.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token, expected none, actual %0d",
                             $time, token_m.token_type);
                    fail_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_m.token_type !== token_t'(want))
                    begin
                        $display("%0t: token_type mismatch, expected %0d (%s), actual %0d",
                                 $time, want, want.name(), token_m.token_type);
                        fail_count++;
                    end
                end
            end
            if (text_m.valid && text_m.ready)
            begin
                scan_byte(text_m.ch);
            end
            outstanding = expected_tokens.size();
        end
    end

endmodule

/* verif/tb_romaji_word_token_scanner_unit.sv */
// Testbench top for the romaji word scanner: byte stimulus, token back-pressure and verdict.
`timescale 1ns / 100ps

module tb_romaji_word_token_scanner_unit;
    import rws_pkg::*;

    localparam ch_t ASCII_SPACE = 8'd32;
    localparam ch_t ASCII_TAB   = 8'd9;
    localparam ch_t ASCII_LF    = 8'd10;
    localparam ch_t ASCII_VT    = 8'd11;
    localparam ch_t ASCII_FF    = 8'd12;
    localparam ch_t ASCII_CR    = 8'd13;
    localparam int  BYTE_TARGET = 650;
    localparam int  CALM_FROM   = 520;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        idle_en;
    int unsigned bytes_sent;
    int unsigned fail_count;
    int unsigned outstanding;
    ch_t         word_q[$];

    rws_char_if  text_chan ();
    rws_token_if token_chan ();

    romaji_word_token_scanner_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_s  (text_chan),
        .token_s (token_chan)
    );

    rws_token_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_m      (text_chan),
        .token_m     (token_chan),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int unsigned gap;
        token_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && ($urandom_range(0, 7) == 0))
            begin
                gap = $urandom_range(1, 17);
                token_chan.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                token_chan.ready <= 1'b1;
            end
        end
    end

    function automatic ch_t random_sep();
        case ($urandom_range(0, 5))
            0:       return ASCII_TAB;
            1:       return ASCII_LF;
            2:       return ASCII_VT;
            3:       return ASCII_FF;
            4:       return ASCII_CR;
            default: return ASCII_SPACE;
        endcase
    endfunction

    task automatic send_byte(input ch_t c);
        int unsigned gap;
        if (idle_en && ($urandom_range(0, 5) == 0))
        begin
            gap = $urandom_range(1, 17);
            text_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_chan.valid <= 1'b1;
        text_chan.ch    <= c;
        do
            @(posedge clk);
        while (!text_chan.ready);
        bytes_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            word_q.push_back(ch_t'(s[i]));
        end
    endtask

    task automatic add_syllable();
        string onset;
        case ($urandom_range(0, 21))
            0:       onset = "";
            1:       onset = "k";
            2:       onset = "s";
            3:       onset = "t";
            4:       onset = "n";
            5:       onset = "h";
            6:       onset = "m";
            7:       onset = "y";
            8:       onset = "r";
            9:       onset = "w";
            10:      onset = "g";
            11:      onset = "z";
            12:      onset = "d";
            13:      onset = "b";
            14:      onset = "p";
            15:      onset = "j";
            16:      onset = "sh";
            17:      onset = "ch";
            18:      onset = "ts";
            19:      onset = "ky";
            20:      onset = "ny";
            default: onset = "ry";
        endcase
        add_text(onset);
        case ($urandom_range(0, 4))
            0:       add_text("a");
            1:       add_text("i");
            2:       add_text("u");
            3:       add_text("e");
            default: add_text("o");
        endcase
        if ($urandom_range(0, 6) == 0)
        begin
            add_text("n");
        end
    endtask

    task automatic flush_word(input ch_t sep);
        foreach (word_q[i])
        begin
            send_byte(word_q[i]);
        end
        send_byte(sep);
        word_q.delete();
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned n;
        int unsigned target;
        ch_t         b;
        string       word_txt;

        rst_n           <= 1'b0;
        text_chan.valid <= 1'b0;
        text_chan.ch    <= '0;
        idle_en          = 1'b1;
        bytes_sent       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short directed words: reserved, period, upper vowel ending, end marker,
        // zero and top byte values, whitespace with no open word.
        add_text("o");
        flush_word(ASCII_TAB);
        add_text(".");
        flush_word(ASCII_LF);
        add_text("kaI");
        flush_word(ASCII_VT);
        add_text("eofm");
        flush_word(ASCII_FF);
        word_q.push_back(8'h00);
        word_q.push_back(8'hFF);
        flush_word(ASCII_CR);
        send_byte(ASCII_SPACE);
        send_byte(ASCII_TAB);
        add_text("n");
        flush_word(ASCII_SPACE);
        add_text("wa");
        flush_word(ASCII_CR);

        while (bytes_sent < BYTE_TARGET)
        begin
            idle_en = (bytes_sent < CALM_FROM) && (((bytes_sent / 60) % 3) != 2);
            pick    = $urandom_range(0, 99);
            if (pick < 35)
            begin
                case ($urandom_range(0, 18))
                    0:       word_txt = "masu";
                    1:       word_txt = "masen";
                    2:       word_txt = "mashita";
                    3:       word_txt = "masendeshita";
                    4:       word_txt = "desu";
                    5:       word_txt = "deshita";
                    6:       word_txt = "o";
                    7:       word_txt = "wa";
                    8:       word_txt = "ni";
                    9:       word_txt = "watashi";
                    10:      word_txt = "anata";
                    11:      word_txt = "kare";
                    12:      word_txt = "kanojo";
                    13:      word_txt = "sore";
                    14:      word_txt = "mata";
                    15:      word_txt = "soshite";
                    16:      word_txt = "shikashi";
                    17:      word_txt = "dakara";
                    default: word_txt = "eofm";
                endcase
                add_text(word_txt);
                case ($urandom_range(0, 7))
                    0:
                    begin
                        if (word_q.size() > 1)
                        begin
                            void'(word_q.pop_back());
                        end
                    end
                    1:       word_q.push_back(ch_t'($urandom_range(97, 122)));
                    2:       add_text("I");
                    default: ;
                endcase
            end
            else if (pick < 65)
            begin
                n = $urandom_range(1, 5);
                repeat (n) add_syllable();
                if ($urandom_range(0, 2) == 0)
                begin
                    add_text($urandom_range(0, 1) ? "I" : "E");
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    word_q.insert($urandom_range(0, word_q.size()),
                                  ch_t'($urandom_range(97, 122)));
                end
            end
            else if (pick < 75)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    add_text("masendeshita");
                end
                target = $urandom_range(13, 22);
                while (word_q.size() < target)
                begin
                    add_syllable();
                end
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    b = ch_t'($urandom_range(0, 255));
                    if ((b == ASCII_SPACE) || ((b >= ASCII_TAB) && (b <= ASCII_CR)))
                    begin
                        b = 8'h00;
                    end
                    word_q.push_back(b);
                end
            end
            else if (pick < 92)
            begin
                case ($urandom_range(0, 3))
                    0:       add_text(".");
                    1:       add_text("..");
                    2:       add_text(".a");
                    default: add_text("a.");
                endcase
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) word_q.push_back(ch_t'($urandom_range(97, 122)));
            end
            flush_word(random_sep());
            if ($urandom_range(0, 6) == 0)
            begin
                send_byte(random_sep());
            end
        end

        // A trailing word with no whitespace after it must not produce a token.
        idle_en = 1'b0;
        send_byte("k");
        send_byte("a");
        text_chan.valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
